// File: design/assert_macros.svh
// Assertion macros shared by the insertion-ordered set RTL.
// Clocked, reset-qualified concurrent assertion wrappers; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ios_pkg.sv
// Shared types and constants for the insertion-ordered set.
// Used by ios_ctrl, ios_dp and insertion_ordered_int_set; no dependencies.
package ios_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int VALUE_W          = 32;
    localparam int COUNT_OUT_W      = 6;
    localparam int OUT_TDATA_W      = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // take new request
        logic rd_scan;     // read slot idx
        logic rd_shift;    // read slot idx+1
        logic mark_found;  // match at slot idx
        logic idx_inc;
        logic add_wr;      // append value at slot count
        logic shift_wr;    // slot idx <= read data
        logic out_load;    // commit count, load result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;    // idx == count
        logic hit;         // read data equals request value
        logic shift_end;   // idx+1 >= count
        logic add_ok;      // add of absent value with room
        logic remove_hit;  // remove of a present value
        logic out_busy;    // result register held by sink
    } dp_status_t;

endpackage

// File: design/ios_ctrl.sv
// Sequencer for the insertion-ordered set: scan, decide, shift, finish.
// Depends on ios_pkg and assert_macros.svh; drives ios_dp via ctrl_cmd_t.
`include "assert_macros.svh"

module ios_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ios_pkg::dp_status_t status,
    output ios_pkg::ctrl_cmd_t  cmd
);

    ios_pkg::state_t state_reg;
    ios_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ios_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ios_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ios_pkg::ST_SCAN_RD;
                end
            end
            ios_pkg::ST_SCAN_RD:
            begin
                state_next = status.scan_end ? ios_pkg::ST_DECIDE : ios_pkg::ST_SCAN_CMP;
            end
            ios_pkg::ST_SCAN_CMP:
            begin
                state_next = status.hit ? ios_pkg::ST_DECIDE : ios_pkg::ST_SCAN_RD;
            end
            ios_pkg::ST_DECIDE:
            begin
                state_next = status.remove_hit ? ios_pkg::ST_SHIFT_RD : ios_pkg::ST_FINISH;
            end
            ios_pkg::ST_SHIFT_RD:
            begin
                state_next = status.shift_end ? ios_pkg::ST_FINISH : ios_pkg::ST_SHIFT_WR;
            end
            ios_pkg::ST_SHIFT_WR:
            begin
                state_next = ios_pkg::ST_SHIFT_RD;
            end
            ios_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ios_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ios_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ios_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ios_pkg::ST_SCAN_RD:
            begin
                cmd.rd_scan = !status.scan_end;
            end
            ios_pkg::ST_SCAN_CMP:
            begin
                cmd.mark_found = status.hit;
                cmd.idx_inc    = !status.hit;
            end
            ios_pkg::ST_DECIDE:
            begin
                cmd.add_wr = status.add_ok;
            end
            ios_pkg::ST_SHIFT_RD:
            begin
                cmd.rd_shift = !status.shift_end;
            end
            ios_pkg::ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ios_pkg::ST_FINISH:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // memory port is used for one purpose at a time
    `ASSERT_CLK(a_one_access, clk, rst_n,
        !((cmd.rd_scan || cmd.rd_shift) && (cmd.add_wr || cmd.shift_wr)),
        "read and write issued together")
    // a request is only taken while no other is in flight
    `ASSERT_NEXT(a_load_starts_scan, clk, rst_n, cmd.load,
        state_reg == ios_pkg::ST_SCAN_RD, "request load did not start a scan")
    // a result leaves only after the finish step
    `ASSERT_NEXT(a_out_then_idle, clk, rst_n, cmd.out_load,
        state_reg == ios_pkg::ST_IDLE, "result load did not return to idle")

endmodule

// File: design/ios_dp.sv
// Datapath for the insertion-ordered set: entry memory, count, index, result register.
// Depends on ios_pkg and assert_macros.svh; sequenced by ios_ctrl.
`include "assert_macros.svh"

module ios_dp
#(
    parameter int CAPACITY = ios_pkg::DEFAULT_CAPACITY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ios_pkg::ctrl_cmd_t                cmd,
    output ios_pkg::dp_status_t               status,
    input  logic [1:0]                        in_cmd,
    input  logic signed [ios_pkg::VALUE_W-1:0] in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_success,
    output logic                              out_was_member,
    output logic [ios_pkg::COUNT_OUT_W-1:0]   out_member_count,
    output logic                              out_set_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [ios_pkg::VALUE_W-1:0] mem [CAPACITY];

    ios_pkg::cmd_t               cmd_reg;
    logic [ios_pkg::VALUE_W-1:0] value_reg;
    logic [ios_pkg::VALUE_W-1:0] rdata_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_p1;
    logic                        found_reg;
    logic                        success;
    logic                        out_valid_reg;
    logic                        success_reg;
    logic                        was_member_reg;
    logic [ios_pkg::COUNT_OUT_W-1:0] member_count_reg;
    logic                        set_full_reg;
    logic [CNT_W+ios_pkg::COUNT_OUT_W-1:0] count_ext;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [ios_pkg::VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]            rd_addr;

    assign idx_p1 = idx_reg + CNT_W'(1);

    always_comb
    begin
        unique case (cmd_reg)
            ios_pkg::CMD_ADD:    success = !found_reg && (count_reg != CAP_C);
            ios_pkg::CMD_REMOVE: success = found_reg;
            ios_pkg::CMD_QUERY:  success = found_reg;
            ios_pkg::CMD_CLEAR:  success = 1'b1;
            default:             success = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        unique case (cmd_reg)
            ios_pkg::CMD_ADD:    if (success) count_next = count_reg + CNT_W'(1);
            ios_pkg::CMD_REMOVE: if (success) count_next = count_reg - CNT_W'(1);
            ios_pkg::CMD_QUERY:  count_next = count_reg;
            ios_pkg::CMD_CLEAR:  count_next = '0;
            default:             count_next = count_reg;
        endcase
    end

    // reported count is the low six bits
    assign count_ext = {{ios_pkg::COUNT_OUT_W{1'b0}}, count_next};

    assign status.scan_end   = (idx_reg == count_reg);
    assign status.hit        = (rdata_reg == value_reg);
    assign status.shift_end  = (idx_p1 >= count_reg);
    assign status.add_ok     = (cmd_reg == ios_pkg::CMD_ADD) && success;
    assign status.remove_hit = (cmd_reg == ios_pkg::CMD_REMOVE) && found_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign wr_en   = cmd.add_wr || cmd.shift_wr;
    assign wr_addr = cmd.add_wr ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_data = cmd.add_wr ? value_reg : rdata_reg;
    assign rd_addr = cmd.rd_shift ? idx_p1[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // entry memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_scan || cmd.rd_shift)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= ios_pkg::cmd_t'(in_cmd);
            value_reg <= in_value;
        end
        if (cmd.out_load)
        begin
            success_reg      <= success;
            was_member_reg   <= found_reg;
            member_count_reg <= count_ext[ios_pkg::COUNT_OUT_W-1:0];
            set_full_reg     <= (count_next == CAP_C);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_p1;
            end
            if (cmd.mark_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_success      = success_reg;
    assign out_was_member   = was_member_reg;
    assign out_member_count = member_count_reg;
    assign out_set_full     = set_full_reg;

    `ASSERT_CLK(a_count_in_range, clk, rst_n, count_reg <= CAP_C,
        "member count above capacity")
    `ASSERT_CLK(a_shift_below_count, clk, rst_n, !cmd.shift_wr || (idx_p1 < count_reg),
        "shift write beyond last member")
    `ASSERT_CLK(a_found_nonempty, clk, rst_n, !cmd.mark_found || (count_reg != '0),
        "match reported in an empty set")

endmodule

// File: design/insertion_ordered_int_set.sv
// Insertion-ordered set of distinct signed 32-bit values: top level.
// Depends on ios_pkg, ios_ctrl and ios_dp.
//
// Holds up to CAPACITY distinct values packed from slot 0 in the order they
// were added. Each request (tuser = command, tdata = value) returns one
// result: success, was_member, the member count after the request (low six
// bits) and a full flag. Add appends an absent value when there is room,
// remove deletes a value and moves every later entry down a slot, query
// reports membership, clear empties the set. Requests are handled one at a
// time: a request scans the members from slot 0, and a hit ends the scan
// early; a remove of a member then moves each later entry down in turn. A
// request waits in its finish step while the previous result is still held
// in the output register for the sink. Each compare and each move steps the
// single read port of the entry memory. The next request is taken as soon
// as the result is in the output register, even if the sink has not yet
// taken it.
// The entry store needs no clearing after reset; only slots below the count
// are ever read.

module insertion_ordered_int_set
#(
    parameter int CAPACITY = ios_pkg::DEFAULT_CAPACITY   // 1 .. 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ios_pkg::VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic [1:0]                      s_axis_tuser,   // [1:0] cmd
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] success, [1] was_member, [7:2] member_count, [8] set_full, [15:9] zero
    output logic [ios_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    ios_pkg::ctrl_cmd_t  cmd;
    ios_pkg::dp_status_t status;

    logic                              out_success;
    logic                              out_was_member;
    logic [ios_pkg::COUNT_OUT_W-1:0]   out_member_count;
    logic                              out_set_full;

    ios_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ios_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_cmd           (s_axis_tuser),
        .in_value         (s_axis_tdata),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_success      (out_success),
        .out_was_member   (out_was_member),
        .out_member_count (out_member_count),
        .out_set_full     (out_set_full)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {7'b0, out_set_full, out_member_count, out_was_member, out_success};

endmodule
